FILE: rtl/eulrot_pkg.sv
// ---------------------------------------------------------------------------
// Euler angle to rotation matrix: shared definitions
// Word types, fixed-point widths, the arctangent table and the rounding,
// clamping and rotation helpers used by the pipeline.
// ---------------------------------------------------------------------------
package eulrot_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int OUT_FRAC_BITS    = 14;
    localparam int FIELD_W          = 16;

    localparam int CORDIC_STEPS     = 20;
    localparam int CORDIC_PER_STAGE = 4;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam int CORDIC_FRAC      = 30;

    // Reduction stage, rotation stages, rounding stage.
    localparam int SC_STAGES        = CORDIC_STAGES + 2;
    // Sine/cosine stages, products, partial rounding, accumulate, output.
    localparam int PIPE_STAGES      = SC_STAGES + 4;

    localparam int CX_W             = CORDIC_FRAC + 3;
    localparam int CZ_W             = 26;
    localparam int TRIG_W           = OUT_FRAC_BITS + 2;
    localparam int PROD_W           = 2 * OUT_FRAC_BITS + 3;

    localparam longint CORDIC_X0    = 64'sd652032874;
    localparam longint ONE          = longint'(1) << OUT_FRAC_BITS;
    localparam int TRIG_SHIFT       = CORDIC_FRAC - OUT_FRAC_BITS;
    localparam longint HALF_TRIG    = (longint'(1) << TRIG_SHIFT) >> 1;
    localparam longint HALF_PROD    = (longint'(1) << OUT_FRAC_BITS) >> 1;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [TRIG_W-1:0]     trig_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [FIELD_W-1:0]    field_t;

    typedef struct packed {
        angle_t heading;
        angle_t pitch;
        angle_t bank;
    } in_word_t;

    typedef struct packed {
        field_t m00;
        field_t m01;
        field_t m02;
        field_t m10;
        field_t m11;
        field_t m12;
        field_t m20;
        field_t m21;
        field_t m22;
    } out_word_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [CZ_W-1:0] z;
        logic                   flip;
    } phase_t;

    // Arctangent of 2^-i, with pi equal to 2^23.
    function automatic logic signed [CZ_W-1:0] atan_val(input int i);
        logic signed [CZ_W-1:0] a;
        unique case (i)
            0:       a = CZ_W'(2097152);
            1:       a = CZ_W'(1238021);
            2:       a = CZ_W'(654136);
            3:       a = CZ_W'(332050);
            4:       a = CZ_W'(166669);
            5:       a = CZ_W'(83416);
            6:       a = CZ_W'(41718);
            7:       a = CZ_W'(20860);
            8:       a = CZ_W'(10430);
            9:       a = CZ_W'(5215);
            10:      a = CZ_W'(2608);
            11:      a = CZ_W'(1304);
            12:      a = CZ_W'(652);
            13:      a = CZ_W'(326);
            14:      a = CZ_W'(163);
            15:      a = CZ_W'(81);
            16:      a = CZ_W'(41);
            17:      a = CZ_W'(20);
            18:      a = CZ_W'(10);
            19:      a = CZ_W'(5);
            default: a = '0;
        endcase
        return a;
    endfunction

    // Takes the top 16 bits of the angle and folds it into -pi/2..pi/2.
    function automatic phase_t reduce_angle(input angle_t a);
        logic [ANGLE_BITS+15:0] ext;
        logic signed [15:0]     u;
        logic signed [16:0]     p;
        phase_t                 r;
        ext    = {a, 16'b0};
        u      = ext[ANGLE_BITS+15 -: 16];
        p      = 17'(u);
        r.flip = 1'b0;
        if (p > 17'sd16384) begin
            p      = p - 17'sd32768;
            r.flip = 1'b1;
        end else if (p < -17'sd16384) begin
            p      = p + 17'sd32768;
            r.flip = 1'b1;
        end
        r.z = CZ_W'(p) <<< 8;
        return r;
    endfunction

    // A group of rotation steps; base is a constant at every call site.
    function automatic cordic_t cordic_run(input cordic_t c, input int base);
        cordic_t                r;
        logic signed [CX_W-1:0] nx;
        int                     i;
        r = c;
        for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
            i = base + j;
            if (r.z >= 0) begin
                nx  = r.x - (r.y >>> i);
                r.y = r.y + (r.x >>> i);
                r.z = r.z - atan_val(i);
            end else begin
                nx  = r.x + (r.y >>> i);
                r.y = r.y - (r.x >>> i);
                r.z = r.z + atan_val(i);
            end
            r.x = nx;
        end
        return r;
    endfunction

    function automatic trig_t trig_round(input logic signed [CX_W-1:0] v, input logic flip);
        logic signed [CX_W:0] r;
        trig_t                t;
        r = (CX_W+1)'(v) + (CX_W+1)'(HALF_TRIG);
        r = r >>> TRIG_SHIFT;
        if (r > (CX_W+1)'(ONE)) begin
            r = (CX_W+1)'(ONE);
        end else if (r < -(CX_W+1)'(ONE)) begin
            r = -(CX_W+1)'(ONE);
        end
        t = TRIG_W'(r);
        return flip ? -t : t;
    endfunction

    function automatic prod_t mul(input trig_t a, input trig_t b);
        logic signed [2*TRIG_W-1:0] f;
        f = a * b;
        return PROD_W'(f);
    endfunction

    // Rounds a product back to the trig format; no clamp is needed there.
    function automatic trig_t prod_round(input prod_t v);
        logic signed [PROD_W:0] r;
        r = (PROD_W+1)'(v) + (PROD_W+1)'(HALF_PROD);
        r = r >>> OUT_FRAC_BITS;
        return TRIG_W'(r);
    endfunction

    function automatic field_t finish(input prod_t v);
        logic signed [PROD_W:0] r;
        r = (PROD_W+1)'(v) + (PROD_W+1)'(HALF_PROD);
        r = r >>> OUT_FRAC_BITS;
        if (r > (PROD_W+1)'(ONE)) begin
            r = (PROD_W+1)'(ONE);
        end else if (r < -(PROD_W+1)'(ONE)) begin
            r = -(PROD_W+1)'(ONE);
        end
        return FIELD_W'(r);
    endfunction

endpackage

FILE: rtl/eulrot_sincos.sv
// ---------------------------------------------------------------------------
// Euler angle to rotation matrix: sine/cosine pipeline
// Folds a binary angle into the right half plane, runs the rotation CORDIC
// over several register stages and rounds the result to the output format.
// ---------------------------------------------------------------------------
module eulrot_sincos (
    input  logic                                 aclk,
    input  logic [eulrot_pkg::SC_STAGES-1:0]     stage_en,
    input  eulrot_pkg::angle_t                   angle,
    output eulrot_pkg::trig_t                    sin_out,
    output eulrot_pkg::trig_t                    cos_out
);

    localparam int NC = eulrot_pkg::CORDIC_STAGES;

    eulrot_pkg::cordic_t cord_reg [NC+1];
    logic                flip_reg [NC+1];
    eulrot_pkg::phase_t  phase_next;
    eulrot_pkg::trig_t   sin_reg;
    eulrot_pkg::trig_t   cos_reg;

    assign phase_next = eulrot_pkg::reduce_angle(angle);

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            cord_reg[0].x <= eulrot_pkg::CX_W'(eulrot_pkg::CORDIC_X0);
            cord_reg[0].y <= '0;
            cord_reg[0].z <= phase_next.z;
            flip_reg[0]   <= phase_next.flip;
        end
    end

    for (genvar k = 1; k <= NC; k++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (stage_en[k]) begin
                cord_reg[k] <= eulrot_pkg::cordic_run(cord_reg[k-1],
                                                      (k - 1) * eulrot_pkg::CORDIC_PER_STAGE);
                flip_reg[k] <= flip_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NC+1]) begin
            sin_reg <= eulrot_pkg::trig_round(cord_reg[NC].y, flip_reg[NC]);
            cos_reg <= eulrot_pkg::trig_round(cord_reg[NC].x, flip_reg[NC]);
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

FILE: rtl/euler_to_rotation_matrix_core.sv
// ---------------------------------------------------------------------------
// Euler angle to rotation matrix core
// Converts heading, pitch and bank binary angles into the nine elements of
// the heading-pitch-bank rotation matrix, 1.0 = 2^14, clamped to +-1.0.
// ---------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one word of three signed angles (2^15 = pi) when
//   s_valid and s_ready are both high. The m_ channel presents one word of
//   nine matrix elements per input word, in the same order.
//   From acceptance to m_valid, a word passes one reduction stage, five
//   rotation stages of four CORDIC steps each, one rounding stage, a
//   product stage, a partial rounding stage, a multiply-accumulate stage and
//   the output register. A new word can enter every cycle that s_ready is high.
//   When the receiver holds m_ready low, the words already in flight close
//   up behind the output register; s_ready drops only once every stage holds
//   a word, so nothing is lost or repeated and the pipeline keeps its data.
//   A synchronous reset (aresetn low) empties the pipeline; no data state
//   is kept between words.
// ---------------------------------------------------------------------------
module euler_to_rotation_matrix_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  eulrot_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output eulrot_pkg::out_word_t m_data
);

    localparam int NS  = eulrot_pkg::PIPE_STAGES;
    localparam int SCS = eulrot_pkg::SC_STAGES;
    localparam int ST_PROD  = SCS;
    localparam int ST_PART  = SCS + 1;
    localparam int ST_MAC   = SCS + 2;
    localparam int ST_OUT   = SCS + 3;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;

    eulrot_pkg::trig_t sh, ch, sp, cp, sb, cb;

    // Product stage.
    eulrot_pkg::prod_t p_shsp_reg, p_chsp_reg;
    eulrot_pkg::prod_t p_chcb_reg, p_shcb_reg, p_chsb_reg, p_sbsh_reg;
    eulrot_pkg::prod_t p_sbcp_reg, p_cbcp_reg, p_shcp_reg, p_chcp_reg;
    eulrot_pkg::trig_t sb1_reg, cb1_reg, sp1_reg;

    // Partial rounding stage.
    eulrot_pkg::trig_t t_reg, w_reg, sb2_reg, cb2_reg, sp2_reg;
    eulrot_pkg::prod_t q_chcb_reg, q_shcb_reg, q_chsb_reg, q_sbsh_reg;
    eulrot_pkg::prod_t q_sbcp_reg, q_cbcp_reg, q_shcp_reg, q_chcp_reg;

    // Accumulate stage.
    eulrot_pkg::prod_t a00_reg, a02_reg, a10_reg, a12_reg;
    eulrot_pkg::prod_t a01_reg, a11_reg, a20_reg, a22_reg;
    eulrot_pkg::trig_t sp3_reg;

    eulrot_pkg::out_word_t out_reg;

    // A stage loads when it is empty or its word moves on this cycle.
    always_comb begin
        for (int k = NS - 1; k >= 0; k--) begin
            if (k == NS - 1) begin
                stage_en[k] = !valid_reg[k] || m_ready;
            end else begin
                stage_en[k] = !valid_reg[k] || stage_en[k+1];
            end
        end
        for (int k = 0; k < NS; k++) begin
            if (!stage_en[k]) begin
                valid_next[k] = valid_reg[k];
            end else if (k == 0) begin
                valid_next[k] = s_valid;
            end else begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NS-1];
    assign m_data  = out_reg;

    eulrot_sincos u_heading (
        .aclk     (aclk),
        .stage_en (stage_en[SCS-1:0]),
        .angle    (s_data.heading),
        .sin_out  (sh),
        .cos_out  (ch)
    );

    eulrot_sincos u_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[SCS-1:0]),
        .angle    (s_data.pitch),
        .sin_out  (sp),
        .cos_out  (cp)
    );

    eulrot_sincos u_bank (
        .aclk     (aclk),
        .stage_en (stage_en[SCS-1:0]),
        .angle    (s_data.bank),
        .sin_out  (sb),
        .cos_out  (cb)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PROD]) begin
            p_shsp_reg <= eulrot_pkg::mul(sh, sp);
            p_chsp_reg <= eulrot_pkg::mul(ch, sp);
            p_chcb_reg <= eulrot_pkg::mul(ch, cb);
            p_shcb_reg <= eulrot_pkg::mul(sh, cb);
            p_chsb_reg <= eulrot_pkg::mul(ch, sb);
            p_sbsh_reg <= eulrot_pkg::mul(sb, sh);
            p_sbcp_reg <= eulrot_pkg::mul(sb, cp);
            p_cbcp_reg <= eulrot_pkg::mul(cb, cp);
            p_shcp_reg <= eulrot_pkg::mul(sh, cp);
            p_chcp_reg <= eulrot_pkg::mul(ch, cp);
            sb1_reg    <= sb;
            cb1_reg    <= cb;
            sp1_reg    <= sp;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_PART]) begin
            t_reg      <= eulrot_pkg::prod_round(p_shsp_reg);
            w_reg      <= eulrot_pkg::prod_round(p_chsp_reg);
            q_chcb_reg <= p_chcb_reg;
            q_shcb_reg <= p_shcb_reg;
            q_chsb_reg <= p_chsb_reg;
            q_sbsh_reg <= p_sbsh_reg;
            q_sbcp_reg <= p_sbcp_reg;
            q_cbcp_reg <= p_cbcp_reg;
            q_shcp_reg <= p_shcp_reg;
            q_chcp_reg <= p_chcp_reg;
            sb2_reg    <= sb1_reg;
            cb2_reg    <= cb1_reg;
            sp2_reg    <= sp1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_MAC]) begin
            a00_reg <= q_chcb_reg + eulrot_pkg::mul(t_reg, sb2_reg);
            a02_reg <= eulrot_pkg::mul(w_reg, sb2_reg) - q_shcb_reg;
            a10_reg <= eulrot_pkg::mul(t_reg, cb2_reg) - q_chsb_reg;
            a12_reg <= q_sbsh_reg + eulrot_pkg::mul(w_reg, cb2_reg);
            a01_reg <= q_sbcp_reg;
            a11_reg <= q_cbcp_reg;
            a20_reg <= q_shcp_reg;
            a22_reg <= q_chcp_reg;
            sp3_reg <= sp2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[ST_OUT]) begin
            out_reg.m00 <= eulrot_pkg::finish(a00_reg);
            out_reg.m01 <= eulrot_pkg::finish(a01_reg);
            out_reg.m02 <= eulrot_pkg::finish(a02_reg);
            out_reg.m10 <= eulrot_pkg::finish(a10_reg);
            out_reg.m11 <= eulrot_pkg::finish(a11_reg);
            out_reg.m12 <= eulrot_pkg::finish(a12_reg);
            out_reg.m20 <= eulrot_pkg::finish(a20_reg);
            // The sine is already within +-1.0, so its negation needs no clamp.
            out_reg.m21 <= eulrot_pkg::FIELD_W'(-sp3_reg);
            out_reg.m22 <= eulrot_pkg::finish(a22_reg);
        end
    end

    // An accepted word always lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> valid_reg[0])
        else $error("accepted word did not enter the first stage");

    // The input side stalls only when every stage is full and the output is held.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&valid_reg) && !m_ready)
        else $error("input stalled while the pipeline had room");

    // Words in flight change only by what enters and what leaves.
    a_word_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(valid_reg) ==
            $past($countones(valid_reg)) + int'($past(s_valid && s_ready))
            - int'($past(m_valid && m_ready)))
        else $error("pipeline word count mismatch");

endmodule

FILE: dv/euler_to_rotation_matrix_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Euler angle to rotation matrix core: self-checking testbench
// Feeds heading, pitch and bank words through the valid/ready input channel,
// first from a directed table and then at random. It predicts the nine
// matrix elements of every accepted word with its own CORDIC and
// fixed-point model, and compares each output word field by field. Both
// channels idle in random bursts, and the receiver once holds off long
// enough to back the pipeline up into the input.
// ---------------------------------------------------------------------------
module euler_to_rotation_matrix_core_test;

    localparam int     LATENCY      = 11;
    localparam int     RANDOM_ITEMS = 1750;
    localparam int     CALM_TAIL    = 150;
    localparam int     HOLD_AT      = 400;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     FRAC         = eulrot_pkg::OUT_FRAC_BITS;
    localparam int     TRIG_STEPS   = 20;
    localparam longint GAIN_SEED    = 64'sd652032874;

    typedef struct packed {
        eulrot_pkg::in_word_t  angles;
        logic                  known;
        eulrot_pkg::out_word_t matrix;
    } row_t;

    localparam eulrot_pkg::out_word_t IDENTITY = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    eulrot_pkg::in_word_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    eulrot_pkg::out_word_t m_data;

    row_t                  stim_q[$];
    eulrot_pkg::out_word_t matrix_q[$];
    int                    errors     = 0;
    int                    seen_count = 0;
    bit                    feed_done  = 1'b0;
    bit                    calm       = 1'b0;
    bit                    hold_off   = 1'b0;

    // Extremes, the fold points at +-pi/2, and the angle of -pi. A typed
    // matrix is used where all sines vanish and the result is the identity.
    row_t directed [19] = '{
        '{'{0, 0, 0},                1'b1, IDENTITY},
        '{'{-32768, -32768, -32768}, 1'b1, IDENTITY},
        '{'{32767, 32767, 32767},    1'b0, '0},
        '{'{16384, 0, 0},            1'b0, '0},
        '{'{-16384, 0, 0},           1'b0, '0},
        '{'{0, 16384, 0},            1'b0, '0},
        '{'{0, -16384, 0},           1'b0, '0},
        '{'{0, 0, 16384},            1'b0, '0},
        '{'{0, 0, -16384},           1'b0, '0},
        '{'{16385, -16385, 16385},   1'b0, '0},
        '{'{-16385, 16385, -16385},  1'b0, '0},
        '{'{8192, 8192, 8192},       1'b0, '0},
        '{'{-8192, 4096, 24576},     1'b0, '0},
        '{'{1, -1, 1},               1'b0, '0},
        '{'{-32768, 0, 16384},       1'b0, '0},
        '{'{32767, -32768, 1},       1'b0, '0},
        '{'{12345, -23456, 30000},   1'b0, '0},
        '{'{-1, -1, -1},             1'b0, '0},
        '{'{0, -32768, 0},           1'b0, '0}
    };

    euler_to_rotation_matrix_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic longint atan_step(input int i);
        case (i)
            0:       return 2097152;
            1:       return 1238021;
            2:       return 654136;
            3:       return 332050;
            4:       return 166669;
            5:       return 83416;
            6:       return 41718;
            7:       return 20860;
            8:       return 10430;
            9:       return 5215;
            10:      return 2608;
            11:      return 1304;
            12:      return 652;
            13:      return 326;
            14:      return 163;
            15:      return 81;
            16:      return 41;
            17:      return 20;
            18:      return 10;
            19:      return 5;
            default: return 0;
        endcase
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        if (s == 0) begin
            return v;
        end
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(input longint v);
        longint one;
        one = longint'(1) << FRAC;
        if (v > one) begin
            return one;
        end else if (v < -one) begin
            return -one;
        end
        return v;
    endfunction

    function automatic void sincos_of(input eulrot_pkg::angle_t a, output longint s,
                                      output longint c);
        longint unsigned raw;
        logic [15:0]     u;
        longint          p;
        longint          x;
        longint          y;
        longint          z;
        longint          nx;
        bit              flip;
        raw  = 64'(unsigned'(a));
        // Keeps the top 16 bits, or shifts a narrow angle up to 16 bits.
        u    = 16'((raw << 16) >> eulrot_pkg::ANGLE_BITS);
        p    = longint'($signed(u));
        flip = 1'b0;
        if (p > 16384) begin
            p    = p - 32768;
            flip = 1'b1;
        end else if (p < -16384) begin
            p    = p + 32768;
            flip = 1'b1;
        end
        x = GAIN_SEED;
        y = 0;
        z = p * 256;
        for (int i = 0; i < TRIG_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_step(i);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_step(i);
            end
            x = nx;
        end
        x = clamp_unit(round_shift(x, 30 - FRAC));
        y = clamp_unit(round_shift(y, 30 - FRAC));
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic eulrot_pkg::field_t to_element(input longint v);
        return eulrot_pkg::FIELD_W'(clamp_unit(round_shift(v, FRAC)));
    endfunction

    function automatic eulrot_pkg::out_word_t rotation_of(input eulrot_pkg::in_word_t a);
        longint                sh;
        longint                ch;
        longint                sp;
        longint                cp;
        longint                sb;
        longint                cb;
        longint                t;
        longint                w;
        eulrot_pkg::out_word_t r;
        sincos_of(a.heading, sh, ch);
        sincos_of(a.pitch, sp, cp);
        sincos_of(a.bank, sb, cb);
        // The pitch cross terms are rounded before the third factor.
        t = round_shift(sh * sp, FRAC);
        w = round_shift(ch * sp, FRAC);
        r.m00 = to_element(ch * cb + t * sb);
        r.m01 = to_element(sb * cp);
        r.m02 = to_element(-sh * cb + w * sb);
        r.m10 = to_element(-ch * sb + t * cb);
        r.m11 = to_element(cb * cp);
        r.m12 = to_element(sb * sh + w * cb);
        r.m20 = to_element(sh * cp);
        r.m21 = eulrot_pkg::FIELD_W'(clamp_unit(-sp));
        r.m22 = to_element(ch * cp);
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic eulrot_pkg::angle_t pick_angle();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        case (sel)
            5:       v = 16384 + int'($urandom_range(0, 8)) - 4;
            6:       v = -16384 + int'($urandom_range(0, 8)) - 4;
            7:       v = -32768 + int'($urandom_range(0, 4));
            8:       v = 32767 - int'($urandom_range(0, 4));
            9:       v = int'($urandom_range(0, 64)) - 32;
            default: v = int'($urandom);
        endcase
        return eulrot_pkg::angle_t'(v);
    endfunction

    initial begin : feeder
        row_t row;
        int   idx;
        int   gap;
        bit   fire;
        bit   quiet;
        for (int i = 0; i < 19; i++) begin
            stim_q.push_back(directed[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            row.angles.heading = pick_angle();
            row.angles.pitch   = pick_angle();
            row.angles.bank    = pick_angle();
            row.known          = 1'b0;
            row.matrix         = '0;
            stim_q.push_back(row);
        end
        idx = 0;
        gap = 0;
        wait (aresetn === 1'b1);
        while (idx < stim_q.size()) begin
            @(posedge aclk);
            fire = s_valid && s_ready;
            if (fire) begin
                if (stim_q[idx].known) begin
                    matrix_q.push_back(stim_q[idx].matrix);
                end else begin
                    matrix_q.push_back(rotation_of(s_data));
                end
                idx++;
            end
            if (idx >= stim_q.size() - CALM_TAIL) begin
                calm = 1'b1;
            end
            quiet = (idx % 256) < 64;
            if (fire || !s_valid) begin
                if (idx == stim_q.size()) begin
                    s_valid <= 1'b0;
                end else if (gap > 0) begin
                    gap--;
                    s_valid <= 1'b0;
                end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
                    gap = $urandom_range(1, 10) - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= stim_q[idx].angles;
                end
            end
        end
        feed_done = 1'b1;
    end

    // ---------------- receiver and checker ----------------

    // The long hold-off lets the pipeline fill and stall the input.
    initial begin : pressure
        wait (seen_count >= HOLD_AT);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin : sink
        eulrot_pkg::out_word_t want;
        eulrot_pkg::out_word_t got;
        eulrot_pkg::field_t    wf;
        eulrot_pkg::field_t    gf;
        int                    stall;
        stall = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = m_data;
                if (matrix_q.size() == 0) begin
                    $error("output word with no input word waiting for it");
                    errors++;
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++) begin
                        wf = want[eulrot_pkg::FIELD_W*(8-k) +: eulrot_pkg::FIELD_W];
                        gf = got[eulrot_pkg::FIELD_W*(8-k) +: eulrot_pkg::FIELD_W];
                        if (gf !== wf) begin
                            $error("m%0d%0d expected %0d got %0d", k / 3, k % 3, wf, gf);
                            errors++;
                        end
                    end
                end
                seen_count++;
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!calm && (seen_count % 256) < 192 && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- run control ----------------

    initial begin : run
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (feed_done);
        while (matrix_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * LATENCY) @(posedge aclk);
        if (errors == 0) begin
            $display("euler_to_rotation_matrix_core_test OK");
        end else begin
            $display("euler_to_rotation_matrix_core_test NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("euler_to_rotation_matrix_core_test NOT OK");
        $finish;
    end

endmodule
